[src/ibfd_pkg.sv]
// Shared constants for the servo-channel frame decoder.
// Used by the channel interfaces and the top level; depends on nothing.
`default_nettype none

package ibfd_pkg;

  localparam int CHANNELS_DEF = 14;
  localparam int CHANNELS_MAX = 30;

  localparam int BYTE_W  = 8;
  localparam int INDEX_W = 4;
  localparam int VALUE_W = 16;
  localparam int SUM_W   = 16;

  localparam logic [BYTE_W-1:0] SYNC_FIRST  = 8'h20;
  localparam logic [BYTE_W-1:0] SYNC_SECOND = 8'h40;
  localparam logic [SUM_W-1:0]  CSUM_BASE   = 16'hFFFF;

endpackage

`default_nettype wire

[src/ibfd_ifs.sv]
// Valid/ready channel interfaces: the received-byte channel and the channel-value result.
// Depends on ibfd_pkg for the field widths.
`default_nettype none

interface ibfd_byte_if
  import ibfd_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface ibfd_chan_if
  import ibfd_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [INDEX_W-1:0] channel_index;
  logic [VALUE_W-1:0] channel_value;
  logic               last_channel;

  modport source (output valid, output channel_index, output channel_value,
                  output last_channel, input ready);
  modport sink (input valid, input channel_index, input channel_value,
                input last_channel, output ready);
endinterface

`default_nettype wire

[src/ibus_frame_decoder.sv]
// Servo-channel frame decoder for a radio-control serial link.
//
// byte_i carries received bytes, one per beat. The decoder hunts for the sync
// pair 0x20 0x40 (a second 0x20 restarts the frame), stores the CHANNELS
// little-endian channel words in a channel RAM and keeps a 16-bit running sum.
// After the two checksum bytes it compares against 0xFFFF minus the sum; a
// good frame is played out on chan_o as CHANNELS beats of index and value,
// with last_channel set on the final one. A bad frame is dropped silently.
//
// byte_i is always ready while receiving. After the last checksum byte of a
// good frame, byte_i is held not ready while the RAM is read out: each
// channel is first read from the RAM and then offered as an output beat, and
// the next channel is not read until that beat is taken. A stalled receiver
// holds the current output beat in the RAM read register; the drain resumes
// when it is taken and byte_i reopens after the last beat.
// Reset returns to sync hunting with a cleared sum; the channel RAM is not
// cleared, since every entry is rewritten by a frame before it is read.
// Depends on ibfd_pkg, ibfd_ifs and ibfd_ram.
`default_nettype none

module ibus_frame_decoder
  import ibfd_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  ibfd_byte_if.sink  byte_i,
  ibfd_chan_if.source chan_o
);

  localparam int CH_AW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int POS_W    = $clog2(2 * CHANNELS + 4);
  localparam int CSUM_POS = 2 * CHANNELS + 2;

  localparam logic [1:0] ST_RX  = 2'd0;
  localparam logic [1:0] ST_RD  = 2'd1;
  localparam logic [1:0] ST_OUT = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [BYTE_W-1:0] csum_lo_q, csum_lo_d;
  logic [BYTE_W-1:0] word_lo_q, word_lo_d;
  logic [CH_AW-1:0]  idx_q, idx_d;

  logic              byte_beat;
  logic [BYTE_W-1:0] b;
  logic [POS_W-1:0]  off;
  logic [POS_W-1:0]  ch_off;
  logic              ram_we;
  logic              ram_re;
  logic [VALUE_W-1:0] ram_wdata;
  logic [VALUE_W-1:0] ram_rdata;
  logic              idx_last;

  assign b         = byte_i.rx_byte;
  assign byte_beat = byte_i.valid && byte_i.ready;
  assign off       = pos_q - POS_W'(2);
  assign ch_off    = off >> 1;
  assign ram_wdata = {b, word_lo_q};
  assign ram_re    = (state_q == ST_RD);
  assign idx_last  = (idx_q == CH_AW'(CHANNELS - 1));

  always_comb begin
    state_d   = state_q;
    pos_d     = pos_q;
    sum_d     = sum_q;
    csum_lo_d = csum_lo_q;
    word_lo_d = word_lo_q;
    idx_d     = idx_q;
    ram_we    = 1'b0;

    case (state_q)
      ST_RX: begin
        if (byte_beat) begin
          if (pos_q == '0) begin
            if (b == SYNC_FIRST) begin
              sum_d = SUM_W'(b);
              pos_d = POS_W'(1);
            end
          end else if (pos_q == POS_W'(1)) begin
            if (b == SYNC_SECOND) begin
              sum_d = sum_q + SUM_W'(b);
              pos_d = POS_W'(2);
            end else if (b == SYNC_FIRST) begin
              sum_d = SUM_W'(b);
            end else begin
              pos_d = '0;
            end
          end else if (pos_q < POS_W'(CSUM_POS)) begin
            // hold the low byte, write the full word on the high byte
            if (!pos_q[0]) begin
              word_lo_d = b;
            end else begin
              ram_we = 1'b1;
            end
            sum_d = sum_q + SUM_W'(b);
            pos_d = pos_q + POS_W'(1);
          end else if (pos_q == POS_W'(CSUM_POS)) begin
            csum_lo_d = b;
            pos_d     = pos_q + POS_W'(1);
          end else begin
            pos_d = '0;
            if ({b, csum_lo_q} == (CSUM_BASE - sum_q)) begin
              idx_d   = '0;
              state_d = ST_RD;
            end
          end
        end
      end
      ST_RD: begin
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (chan_o.ready) begin
          if (idx_last) begin
            state_d = ST_RX;
          end else begin
            idx_d   = idx_q + CH_AW'(1);
            state_d = ST_RD;
          end
        end
      end
      default: begin
        state_d = ST_RX;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_RX;
      pos_q     <= '0;
      sum_q     <= '0;
      csum_lo_q <= '0;
      idx_q     <= '0;
    end else begin
      state_q   <= state_d;
      pos_q     <= pos_d;
      sum_q     <= sum_d;
      csum_lo_q <= csum_lo_d;
      idx_q     <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_lo_q <= word_lo_d;
  end

  ibfd_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (CHANNELS),
    .AW    (CH_AW)
  ) u_chan_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ch_off[CH_AW-1:0]),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  assign byte_i.ready         = (state_q == ST_RX);
  assign chan_o.valid         = (state_q == ST_OUT);
  assign chan_o.channel_index = INDEX_W'(idx_q);
  assign chan_o.channel_value = ram_rdata;
  assign chan_o.last_channel  = idx_last;

endmodule

`default_nettype wire

[src/ibfd_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Standalone; no package needed.
`default_nettype none

module ibfd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 14,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire
